FILE: rtl/core/newton_interpolation_engine_macros.svh
// ---------------------------------------------------------------------------
// Newton interpolation engine assertion macros
// Concurrent assertion wrappers shared by the RTL of the engine.
// ---------------------------------------------------------------------------
`ifndef NEWTON_INTERPOLATION_ENGINE_MACROS_SVH
`define NEWTON_INTERPOLATION_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside of reset.
`define NIE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("newton_interpolation_engine: assertion failed");
// Checked on every clock edge, reset included.
`define NIE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("newton_interpolation_engine: reset assertion failed");
`else
`define NIE_ASSERT(lbl, prop)
`define NIE_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: rtl/core/nie_pkg.sv
// ---------------------------------------------------------------------------
// Newton interpolation engine package
// Word format, payload structs, control structs and saturation helpers.
// ---------------------------------------------------------------------------
package nie_pkg;

  localparam int MAX_POINTS = 16;
  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int PROD_BITS  = 2 * WORD_BITS;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WORD_BITS:0]   wide_t;
  typedef logic [IDX_BITS-1:0]         idx_t;
  typedef logic [CNT_BITS-1:0]         cnt_t;

  localparam word_t UNIT = word_t'(1) << FRAC_BITS;

  typedef struct packed {
    logic  op;
    word_t x_val;
    word_t y_val;
  } in_t;

  typedef struct packed {
    word_t      value;
    logic [1:0] status;
    cnt_t       point_count;
  } out_t;

  typedef struct packed {
    word_t node;
    word_t tail;
    word_t lead;
  } cell_word_t;

  typedef struct packed {
    logic fwd;
    logic bwd;
    logic we;
  } node_ctl_t;

  typedef struct packed {
    logic fwd;
    logic bwd;
    logic tail_we;
    logic lead_we;
  } coef_ctl_t;

  typedef struct packed {
    word_t value;
    logic  ovf;
  } sat_t;

  // Clamp a sign and magnitude pair to the signed word range.
  function automatic sat_t sat_mag(input logic neg, input logic [PROD_BITS-1:0] mag);
    logic [PROD_BITS-1:0] lim;
    logic [PROD_BITS-1:0] m;
    sat_t                 r;
    lim = PROD_BITS'({1'b0, {(WORD_BITS-1){1'b1}}}) + PROD_BITS'(neg);
    r.ovf = (mag > lim);
    m = r.ovf ? lim : mag;
    r.value = neg ? word_t'(-m) : word_t'(m);
    return r;
  endfunction

  // Clamp a one-bit-wider signed sum or difference to the word range.
  function automatic sat_t sat_wide(input wide_t s);
    logic [WORD_BITS:0] mag;
    mag = s[WORD_BITS] ? (WORD_BITS+1)'(-s) : (WORD_BITS+1)'(s);
    return sat_mag(s[WORD_BITS], PROD_BITS'(mag));
  endfunction

  // Step a ring position by one with wrap-around.
  function automatic idx_t idx_step(input idx_t i, input logic up);
    idx_t r;
    if (up) begin
      r = (i == idx_t'(MAX_POINTS - 1)) ? '0 : i + idx_t'(1);
    end else begin
      r = (i == '0) ? idx_t'(MAX_POINTS - 1) : i - idx_t'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/nie_cell.sv
// ---------------------------------------------------------------------------
// Newton interpolation engine ring cell
// Holds one node abscissa, one running difference and one coefficient.
// ---------------------------------------------------------------------------
module nie_cell (
  input  logic               clk,
  input  nie_pkg::node_ctl_t node_ctl,
  input  nie_pkg::coef_ctl_t coef_ctl,
  input  nie_pkg::cell_word_t from_next,
  input  nie_pkg::cell_word_t from_prev,
  input  nie_pkg::word_t     wr_node,
  input  nie_pkg::word_t     wr_coef,
  input  nie_pkg::word_t     probe_x,
  output nie_pkg::cell_word_t word_q,
  output logic               hit
);
  import nie_pkg::*;

  word_t node_r;
  word_t tail_r;
  word_t lead_r;

  // The node ring and the coefficient ring rotate independently.
  always_ff @(posedge clk) begin
    if (node_ctl.fwd) begin
      node_r <= from_next.node;
    end else if (node_ctl.bwd) begin
      node_r <= from_prev.node;
    end else if (node_ctl.we) begin
      node_r <= wr_node;
    end
    if (coef_ctl.fwd) begin
      tail_r <= from_next.tail;
      lead_r <= from_next.lead;
    end else if (coef_ctl.bwd) begin
      tail_r <= from_prev.tail;
      lead_r <= from_prev.lead;
    end else begin
      if (coef_ctl.tail_we) begin
        tail_r <= wr_coef;
      end
      if (coef_ctl.lead_we) begin
        lead_r <= wr_coef;
      end
    end
  end

  assign word_q = '{node: node_r, tail: tail_r, lead: lead_r};
  assign hit    = (node_r == probe_x);

endmodule

FILE: rtl/core/nie_div.sv
// ---------------------------------------------------------------------------
// Newton interpolation engine divider
// Radix-2 restoring divider giving a saturated fixed-point quotient.
// ---------------------------------------------------------------------------
module nie_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  nie_pkg::wide_t num,
  input  nie_pkg::wide_t den,
  output logic           busy,
  output logic           done,
  output nie_pkg::sat_t  res
);
  import nie_pkg::*;

  localparam int STEP_BITS = $clog2(WORD_BITS);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t                        state_r;
  logic [STEP_BITS-1:0]           step_r;
  logic                           neg_r;
  logic                           big_r;
  logic [WORD_BITS-1:0]           dmag_r;
  logic [WORD_BITS-1:0]           rem_r;
  logic [WORD_BITS-1:0]           low_r;
  logic [WORD_BITS-1:0]           quo_r;
  logic                           done_r;
  sat_t                           res_r;

  logic [WORD_BITS:0]             nabs;
  logic [WORD_BITS:0]             dabs;
  logic [WORD_BITS+FRAC_BITS-1:0] numer;
  logic [FRAC_BITS-1:0]           numer_hi;
  logic [WORD_BITS:0]             rem_sh;
  logic                           qbit;

  always_comb begin
    nabs     = num[WORD_BITS] ? (WORD_BITS+1)'(-num) : (WORD_BITS+1)'(num);
    dabs     = den[WORD_BITS] ? (WORD_BITS+1)'(-den) : (WORD_BITS+1)'(den);
    numer    = {nabs[WORD_BITS-1:0], {FRAC_BITS{1'b0}}};
    numer_hi = numer[WORD_BITS+FRAC_BITS-1:WORD_BITS];
    rem_sh   = {rem_r, low_r[WORD_BITS-1]};
    qbit     = (rem_sh >= {1'b0, dmag_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == D_FIN);
      case (state_r)
        D_IDLE: begin
          if (start) begin
            neg_r  <= num[WORD_BITS] ^ den[WORD_BITS];
            dmag_r <= dabs[WORD_BITS-1:0];
            rem_r  <= WORD_BITS'(numer_hi);
            low_r  <= numer[WORD_BITS-1:0];
            quo_r  <= '0;
            step_r <= '0;
            // A quotient of a full word or more saturates at once.
            big_r  <= (WORD_BITS'(numer_hi) >= dabs[WORD_BITS-1:0]);
            state_r <= (WORD_BITS'(numer_hi) >= dabs[WORD_BITS-1:0]) ? D_FIN : D_RUN;
          end
        end
        D_RUN: begin
          rem_r  <= qbit ? WORD_BITS'(rem_sh - {1'b0, dmag_r}) : rem_sh[WORD_BITS-1:0];
          quo_r  <= {quo_r[WORD_BITS-2:0], qbit};
          low_r  <= {low_r[WORD_BITS-2:0], 1'b0};
          step_r <= step_r + STEP_BITS'(1);
          if (step_r == STEP_BITS'(WORD_BITS - 1)) begin
            state_r <= D_FIN;
          end
        end
        D_FIN: begin
          res_r   <= sat_mag(neg_r, big_r ? {PROD_BITS{1'b1}} : PROD_BITS'(quo_r));
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign busy = (state_r != D_IDLE);
  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: rtl/core/nie_mul.sv
// ---------------------------------------------------------------------------
// Newton interpolation engine multiplier
// Two-stage fixed-point multiply with rescale and saturation.
// ---------------------------------------------------------------------------
module nie_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  nie_pkg::word_t a,
  input  nie_pkg::word_t b,
  output logic           done,
  output nie_pkg::sat_t  res
);
  import nie_pkg::*;

  logic                 v1_r;
  logic                 done_r;
  logic                 neg_r;
  logic [PROD_BITS-1:0] prod_r;
  sat_t                 res_r;
  logic [WORD_BITS-1:0] amag;
  logic [WORD_BITS-1:0] bmag;

  always_comb begin
    amag = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
    bmag = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(amag) * PROD_BITS'(bmag);
    neg_r  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
    res_r  <= sat_mag(neg_r, prod_r >> FRAC_BITS);
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: rtl/core/newton_interpolation_engine.sv
// ---------------------------------------------------------------------------
// Newton interpolation engine
// Incremental Newton divided-difference interpolation in signed Q16.16.
// ---------------------------------------------------------------------------
// The engine stores up to 16 interpolation nodes in a ring of cells, one cell
// per node, each cell also keeping the newest divided difference and the
// leading coefficient of its order. An add transaction (op 0) appends the
// node (x_val, y_val) and updates the anti-diagonal of the difference table
// with one division per stored order; its result carries the new highest
// order coefficient. An evaluate transaction (op 1) returns the Newton form
// of the polynomial at x_val. Each transaction returns exactly one result
// with a status: table full or duplicate abscissa leave the table untouched
// and return zero, and any fixed-point saturation returns status 3 with the
// clamped value. Only one transaction is worked on at a time; a finished
// result waits in the output register while the next transaction is taken.
// Timing: the node ring and the coefficient ring rotate one cell per cycle
// to bring the wanted entries to cell 0, where the shared arithmetic reads
// them. An add with n stored nodes runs one division per stored node on the
// shared divider, with ring steps between the divisions. An evaluate with n
// nodes runs ring steps and up to two products per node on the shared
// two-stage multiplier. Full and duplicate cases skip the arithmetic.
// ---------------------------------------------------------------------------
`include "newton_interpolation_engine_macros.svh"

module newton_interpolation_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  nie_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output nie_pkg::out_t out_data
);
  import nie_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SEEK, S_ADIV, S_AWAIT, S_AFIN,
    S_ETERM, S_EWAIT, S_EBAS, S_EBWAIT, S_OUT
  } state_t;

  state_t     state_r;
  state_t     after_r;
  logic       op_r;
  word_t      x_r;
  word_t      y_r;
  cnt_t       count_r;
  cnt_t       j_r;
  word_t      cur_r;
  word_t      acc_r;
  word_t      basis_r;
  word_t      fac_r;
  logic       ovf_r;
  idx_t       off_node_r;
  idx_t       off_coef_r;
  idx_t       tgt_node_r;
  idx_t       tgt_coef_r;
  word_t      res_value_r;
  logic [1:0] res_status_r;
  cnt_t       res_count_r;
  logic       out_valid_r;
  out_t       out_data_r;

  // Ring of cells. Cell k holds entry (offset + k) of each store.
  cell_word_t cell_q [MAX_POINTS];
  node_ctl_t  node_ctl [MAX_POINTS];
  coef_ctl_t  coef_ctl [MAX_POINTS];
  logic [MAX_POINTS-1:0] hit_vec;
  logic [MAX_POINTS-1:0] live_vec;

  node_ctl_t  node_ctl0;
  coef_ctl_t  coef_ctl0;
  logic       node_move;
  logic       coef_move;
  logic       node_back;
  logic       coef_back;
  logic       dup;
  idx_t       n_idx;

  logic       div_start;
  logic       div_busy;
  logic       div_done;
  sat_t       div_res;
  wide_t      div_num;
  wide_t      div_den;

  logic       mul_start;
  logic       mul_done;
  sat_t       mul_res;
  word_t      mul_a;
  word_t      mul_b;

  sat_t       sum_sat;
  sat_t       fac_sat;
  logic       eval_ovf;

  // -------------------------------------------------------------------------
  // Ring movement: each ring steps toward its target position, backward when
  // the target is one below the current position and forward otherwise.
  // -------------------------------------------------------------------------
  always_comb begin
    node_back = (tgt_node_r == idx_step(off_node_r, 1'b0));
    coef_back = (tgt_coef_r == idx_step(off_coef_r, 1'b0));
    node_move = (state_r == S_SEEK) && (off_node_r != tgt_node_r);
    coef_move = (state_r == S_SEEK) && (off_coef_r != tgt_coef_r);
    node_ctl0 = '{fwd: node_move && !node_back, bwd: node_move && node_back,
                  we: (state_r == S_AFIN)};
    coef_ctl0 = '{fwd: coef_move && !coef_back, bwd: coef_move && coef_back,
                  tail_we: ((state_r == S_AWAIT) && div_done) || (state_r == S_AFIN),
                  lead_we: (state_r == S_AFIN)};
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    logic [IDX_BITS:0] pos_sum;

    // Only cell 0 takes writes; every cell follows the ring shifts.
    assign node_ctl[k] = '{fwd: node_ctl0.fwd, bwd: node_ctl0.bwd,
                           we: node_ctl0.we && (k == 0)};
    assign coef_ctl[k] = '{fwd: coef_ctl0.fwd, bwd: coef_ctl0.bwd,
                           tail_we: coef_ctl0.tail_we && (k == 0),
                           lead_we: coef_ctl0.lead_we && (k == 0)};

    // Entry index held here, used to mask nodes that were never written.
    always_comb begin
      pos_sum = (IDX_BITS+1)'(off_node_r) + (IDX_BITS+1)'(k);
      if (pos_sum >= (IDX_BITS+1)'(MAX_POINTS)) begin
        pos_sum = pos_sum - (IDX_BITS+1)'(MAX_POINTS);
      end
    end
    assign live_vec[k] = (CNT_BITS'(pos_sum) < count_r);

    nie_cell u_cell (
      .clk       (clk),
      .node_ctl  (node_ctl[k]),
      .coef_ctl  (coef_ctl[k]),
      .from_next (cell_q[(k + 1) % MAX_POINTS]),
      .from_prev (cell_q[(k + MAX_POINTS - 1) % MAX_POINTS]),
      .wr_node   (x_r),
      .wr_coef   (cur_r),
      .probe_x   (x_r),
      .word_q    (cell_q[k]),
      .hit       (hit_vec[k])
    );
  end

  assign dup   = |(hit_vec & live_vec);
  assign n_idx = count_r[IDX_BITS-1:0];

  // -------------------------------------------------------------------------
  // Shared arithmetic, fed from cell 0.
  // -------------------------------------------------------------------------
  always_comb begin
    div_num   = wide_t'(cur_r) - wide_t'(cell_q[0].tail);
    div_den   = wide_t'(x_r) - wide_t'(cell_q[0].node);
    div_start = (state_r == S_ADIV);
    mul_start = (state_r == S_ETERM) || (state_r == S_EBAS);
    mul_a     = (state_r == S_ETERM) ? cell_q[0].lead : basis_r;
    mul_b     = (state_r == S_ETERM) ? basis_r : fac_r;
    sum_sat   = sat_wide(wide_t'(acc_r) + wide_t'(mul_res.value));
    fac_sat   = sat_wide(wide_t'(x_r) - wide_t'(cell_q[0].node));
    eval_ovf  = ovf_r || mul_res.ovf || sum_sat.ovf;
  end

  nie_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .res   (div_res)
  );

  nie_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // -------------------------------------------------------------------------
  // Sequencer.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= S_IDLE;
      count_r     <= '0;
      off_node_r  <= '0;
      off_coef_r  <= '0;
      tgt_node_r  <= '0;
      tgt_coef_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_OUT the output register is reloaded instead of drained.
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (node_move) begin
        off_node_r <= idx_step(off_node_r, !node_back);
      end
      if (coef_move) begin
        off_coef_r <= idx_step(off_coef_r, !coef_back);
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_data.op;
            x_r     <= in_data.x_val;
            y_r     <= in_data.y_val;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          ovf_r       <= 1'b0;
          res_count_r <= count_r;
          res_value_r <= '0;
          if (op_r == OP_EVAL) begin
            if (count_r == '0) begin
              res_status_r <= ST_OK;
              state_r      <= S_OUT;
            end else begin
              j_r        <= '0;
              basis_r    <= UNIT;
              acc_r      <= '0;
              tgt_node_r <= '0;
              tgt_coef_r <= '0;
              after_r    <= S_ETERM;
              state_r    <= S_SEEK;
            end
          end else if (count_r == CNT_BITS'(MAX_POINTS)) begin
            res_status_r <= ST_FULL;
            state_r      <= S_OUT;
          end else if (dup) begin
            res_status_r <= ST_DUP;
            state_r      <= S_OUT;
          end else begin
            cur_r      <= y_r;
            j_r        <= CNT_BITS'(1);
            tgt_coef_r <= '0;
            if (count_r == '0) begin
              tgt_node_r <= '0;
              after_r    <= S_AFIN;
            end else begin
              tgt_node_r <= n_idx - idx_t'(1);
              after_r    <= S_ADIV;
            end
            state_r <= S_SEEK;
          end
        end
        S_SEEK: begin
          if (!node_move && !coef_move) begin
            state_r <= after_r;
          end
        end
        S_ADIV: begin
          state_r <= S_AWAIT;
        end
        S_AWAIT: begin
          if (div_done) begin
            cur_r <= div_res.value;
            ovf_r <= ovf_r || div_res.ovf;
            if (j_r == count_r) begin
              tgt_coef_r <= n_idx;
              tgt_node_r <= n_idx;
              after_r    <= S_AFIN;
            end else begin
              tgt_coef_r <= j_r[IDX_BITS-1:0];
              tgt_node_r <= n_idx - j_r[IDX_BITS-1:0] - idx_t'(1);
              after_r    <= S_ADIV;
              j_r        <= j_r + CNT_BITS'(1);
            end
            state_r <= S_SEEK;
          end
        end
        S_AFIN: begin
          res_value_r  <= cur_r;
          res_status_r <= ovf_r ? ST_OVF : ST_OK;
          res_count_r  <= count_r + CNT_BITS'(1);
          state_r      <= S_OUT;
        end
        S_ETERM: begin
          state_r <= S_EWAIT;
        end
        S_EWAIT: begin
          if (mul_done) begin
            acc_r <= sum_sat.value;
            if ((j_r + CNT_BITS'(1)) < count_r) begin
              fac_r   <= fac_sat.value;
              ovf_r   <= eval_ovf || fac_sat.ovf;
              state_r <= S_EBAS;
            end else begin
              res_value_r  <= sum_sat.value;
              res_status_r <= eval_ovf ? ST_OVF : ST_OK;
              state_r      <= S_OUT;
            end
          end
        end
        S_EBAS: begin
          state_r <= S_EBWAIT;
        end
        S_EBWAIT: begin
          if (mul_done) begin
            basis_r    <= mul_res.value;
            ovf_r      <= ovf_r || mul_res.ovf;
            j_r        <= j_r + CNT_BITS'(1);
            tgt_node_r <= idx_t'(j_r + CNT_BITS'(1));
            tgt_coef_r <= idx_t'(j_r + CNT_BITS'(1));
            after_r    <= S_ETERM;
            state_r    <= S_SEEK;
          end
        end
        S_OUT: begin
          // The node count commits together with the result it reports.
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{value: res_value_r, status: res_status_r,
                             point_count: res_count_r};
            count_r     <= res_count_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `NIE_ASSERT(a_count_bound, count_r <= CNT_BITS'(MAX_POINTS))
  `NIE_ASSERT(a_out_count, out_valid_r |-> out_data_r.point_count == count_r)
  `NIE_ASSERT(a_div_idle, div_start |-> !div_busy)
  `NIE_ASSERT(a_accept_check, (in_valid && !in_stall) |=> state_r == S_CHECK)
  `NIE_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r))

endmodule

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// Newton interpolation engine testbench
// Feeds add and evaluate transactions through a short directed table and then
// a random phase. Every result is compared against a typed-in result or an
// in-bench prediction of the divided-difference table and of the Newton-form evaluation.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nie_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  always #1 clk = ~clk;

  newton_interpolation_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Shadow copy of the interpolation table, kept in step with every accepted
  // input transaction.
  word_t node_tab[MAX_POINTS];
  word_t lead_tab[MAX_POINTS];
  word_t tail_tab[MAX_POINTS];
  int    node_cnt = 0;
  bit    sat_hit;

  out_t  result_fifo[$];
  int    mismatches = 0;
  int    results_seen = 0;
  int    adds_sent = 0;
  int    evals_sent = 0;
  int    overflow_seen = 0;
  int    idle_cycles = 0;

  // Clamp a sign and magnitude pair to the signed 32-bit word, noting any clamp.
  function automatic word_t clamp_mag(bit neg, logic [63:0] mag);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (mag > lim) begin
      sat_hit = 1'b1;
      mag = lim;
    end
    return neg ? word_t'(-mag) : word_t'(mag);
  endfunction

  function automatic logic [63:0] mag_of(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic word_t clamp_word(longint v);
    return clamp_mag(v < 0, mag_of(v));
  endfunction

  // Fixed-point product, truncated toward zero.
  function automatic word_t fx_mul(longint a, longint b);
    return clamp_mag((a < 0) != (b < 0), (mag_of(a) * mag_of(b)) >> FRAC_BITS);
  endfunction

  // Fixed-point quotient of two exact differences, truncated toward zero.
  function automatic word_t fx_div(longint num, longint den);
    if (den == 0) begin
      return clamp_mag((num < 0) != (den < 0), '1);
    end
    return clamp_mag((num < 0) != (den < 0), (mag_of(num) << FRAC_BITS) / mag_of(den));
  endfunction

  // Work out the result of one transaction and advance the shadow table.
  function automatic out_t predict_interp(in_t t);
    out_t   r;
    longint cur;
    longint nxt;
    longint basis;
    longint acc;
    longint term;
    bit     dup;
    int     n;
    sat_hit = 1'b0;
    r.value = '0;
    r.status = ST_OK;
    n = node_cnt;
    if (t.op == OP_ADD) begin
      dup = 1'b0;
      for (int j = 0; j < n; j++) begin
        if (node_tab[j] == t.x_val) dup = 1'b1;
      end
      if (n >= MAX_POINTS) begin
        r.status = ST_FULL;
      end else if (dup) begin
        r.status = ST_DUP;
      end else begin
        cur = t.y_val;
        node_tab[n] = t.x_val;
        for (int j = 1; j <= n; j++) begin
          nxt = fx_div(cur - longint'(tail_tab[j-1]),
                       longint'(t.x_val) - longint'(node_tab[n-j]));
          tail_tab[j-1] = word_t'(cur);
          cur = nxt;
        end
        tail_tab[n] = word_t'(cur);
        lead_tab[n] = word_t'(cur);
        node_cnt = n + 1;
        r.value = word_t'(cur);
      end
    end else if (n > 0) begin
      basis = longint'(UNIT);
      acc = 0;
      for (int j = 0; j < n; j++) begin
        term = fx_mul(lead_tab[j], basis);
        acc = clamp_word(acc + term);
        if (j + 1 < n) begin
          basis = fx_mul(basis, clamp_word(longint'(t.x_val) - longint'(node_tab[j])));
        end
      end
      r.value = word_t'(acc);
    end
    if (r.status == ST_OK && sat_hit) r.status = ST_OVF;
    r.point_count = cnt_t'(node_cnt);
    return r;
  endfunction

  // Directed table. Rows with a typed-in result compare against it directly;
  // the others rely on the prediction.
  typedef struct {
    logic  op;
    word_t x;
    word_t y;
    bit    fixed;
    out_t  res;
  } row_t;

  localparam word_t WMAX = 32'sh7fff_ffff;
  localparam word_t WMIN = 32'sh8000_0000;

  row_t directed[] = '{
    // Evaluate on an empty table gives zero.
    '{OP_EVAL, 32'sh0001_0000, '0, 1, '{'0, ST_OK, 5'd0}},
    // The first node's coefficient is its ordinate.
    '{OP_ADD,  '0, WMAX, 1, '{WMAX, ST_OK, 5'd1}},
    // Repeated abscissa is refused.
    '{OP_ADD,  '0, 32'sh0005_0000, 1, '{'0, ST_DUP, 5'd1}},
    '{OP_EVAL, WMIN, '0, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh0001_0000, WMIN, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  -32'sh0001_0000, '0, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  WMAX, 32'sh0000_8000, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  WMIN, -32'sh0000_0001, 0, '{'0, ST_OK, 5'd0}},
    '{OP_EVAL, WMAX, '0, 0, '{'0, ST_OK, 5'd0}},
    '{OP_EVAL, 32'sh0000_8000, '0, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh0002_0000, 32'sh0003_0000, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh0003_0000, -32'sh0002_0000, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh0004_0000, 32'sh0001_8000, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh0005_0000, 32'sh0000_0001, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh0006_0000, 32'sh0007_0000, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh0007_0000, -32'sh0004_0000, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh0008_0000, 32'sh0002_0000, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh0009_0000, '0, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh000a_0000, 32'sh0001_0000, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh000b_0000, -32'sh0001_0000, 0, '{'0, ST_OK, 5'd0}},
    '{OP_ADD,  32'sh000c_0000, 32'sh0005_0000, 0, '{'0, ST_OK, 5'd0}},
    // Sixteen nodes stored: the next add is refused as table full.
    '{OP_ADD,  32'sh0064_0000, 32'sh0001_0000, 1, '{'0, ST_FULL, 5'd16}},
    '{OP_EVAL, 32'sh0004_8000, '0, 0, '{'0, ST_OK, 5'd0}}
  };

  function automatic int pick_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Present one transaction and hold it until accepted. The prediction is
  // queued at the accepting edge so that it always precedes the result.
  task automatic send_item(in_t t, bit fixed, out_t res);
    out_t   pred;
    int     gap;
    gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    pred = predict_interp(t);
    result_fifo.insert(result_fifo.size(), fixed ? res : pred);
    if (t.op == OP_ADD) adds_sent++;
    else evals_sent++;
  endtask

  function automatic word_t rand_x();
    case ($urandom_range(0, 3))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 2 * 32'h0010_0000)) - 32'sh0010_0000;
      2: return word_t'($urandom_range(0, 32'h000c_0000));
      default: return word_t'($urandom_range(0, 15)) <<< FRAC_BITS;
    endcase
  endfunction

  // Result side: random stall with occasional long stretches, checking every
  // accepted result transaction against the oldest expectation.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 2) begin
      out_stall <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.status == ST_OVF) overflow_seen++;
      if (result_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", out_data);
      end else if (result_fifo[0] !== out_data) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected value %0d status %0d count %0d, got %0d %0d %0d",
                   result_fifo[0].value, result_fifo[0].status, result_fifo[0].point_count,
                   out_data.value, out_data.status, out_data.point_count);
        end
        void'(result_fifo.pop_front());
      end else begin
        void'(result_fifo.pop_front());
      end
    end
  end

  // Watchdog over cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", result_fifo.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_t t;
    int  drain;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      t.op = directed[i].op;
      t.x_val = directed[i].x;
      t.y_val = directed[i].y;
      send_item(t, directed[i].fixed, directed[i].res);
    end

    // The table is full from here on, so most of the random phase evaluates
    // the fitted polynomial; a minority of adds keep checking the full case.
    for (int i = 0; i < 1000; i++) begin
      t.op = ($urandom_range(0, 4) == 0) ? OP_ADD : OP_EVAL;
      t.x_val = rand_x();
      t.y_val = word_t'($urandom);
      send_item(t, 1'b0, '0);
    end
    in_valid <= 1'b0;

    drain = 0;
    while (result_fifo.size() != 0 && drain < WATCHDOG_LIMIT * 4) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d adds and %0d evaluates, %0d results checked, %0d saturated",
             adds_sent, evals_sent, results_seen, overflow_seen);
    if (mismatches == 0 && result_fifo.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, result_fifo.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
